// File: hw/rtl/orp_pkg.sv
// ----------------------------------------------------------------------------
// orp_pkg
// Shared types and codes for the object-file record parser.
// ----------------------------------------------------------------------------
package orp_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_HDR1   = 4'd0;
  localparam logic [3:0] PH_HDR2   = 4'd1;
  localparam logic [3:0] PH_ADDR_H = 4'd2;
  localparam logic [3:0] PH_ADDR_L = 4'd3;
  localparam logic [3:0] PH_CNT_H  = 4'd4;
  localparam logic [3:0] PH_CNT_L  = 4'd5;
  localparam logic [3:0] PH_WORD_H = 4'd6;
  localparam logic [3:0] PH_WORD_L = 4'd7;
  localparam logic [3:0] PH_LABEL  = 4'd8;

  // Record kinds
  localparam logic [1:0] REC_UNKNOWN = 2'd0;
  localparam logic [1:0] REC_CODE    = 2'd1;
  localparam logic [1:0] REC_DATA    = 2'd2;
  localparam logic [1:0] REC_LABEL   = 2'd3;

  // Result item kinds
  localparam logic [1:0] ITEM_WORD        = 2'd0;
  localparam logic [1:0] ITEM_LABEL_CHAR  = 2'd1;
  localparam logic [1:0] ITEM_LABEL_EMPTY = 2'd2;

  // Header byte pairs
  localparam logic [7:0] HDR_CODE_1  = 8'hCA;
  localparam logic [7:0] HDR_CODE_2  = 8'hDE;
  localparam logic [7:0] HDR_DATA_1  = 8'hDA;
  localparam logic [7:0] HDR_DATA_2  = 8'hDA;
  localparam logic [7:0] HDR_LABEL_1 = 8'hC3;
  localparam logic [7:0] HDR_LABEL_2 = 8'hB7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_end;
  } orp_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] target_address;
    logic [15:0] item_value;
    logic        label_last;
  } orp_out_t;

endpackage

// File: hw/rtl/orp_parser.sv
// ----------------------------------------------------------------------------
// orp_parser
// Record state machine: advances on each accepted byte, flags a result.
// ----------------------------------------------------------------------------
module orp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  orp_pkg::orp_in_t in_data_i,
  output logic             res_valid_o,
  output orp_pkg::orp_out_t res_data_o
);

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  hdr1_q, hdr1_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] count_full;
  logic [7:0]  b;

  assign b          = in_data_i.data_byte;
  assign count_full = {count_q[15:8], b};

  always_comb begin
    phase_d     = phase_q;
    hdr1_d      = hdr1_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    count_d     = count_q;
    hi_d        = hi_q;
    res_valid_o = 1'b0;
    res_data_o  = '0;
    if (in_data_i.file_end) begin
      phase_d = orp_pkg::PH_HDR1;
      hdr1_d  = '0;
      kind_d  = orp_pkg::REC_UNKNOWN;
      addr_d  = '0;
      count_d = '0;
      hi_d    = '0;
    end else begin
      unique case (phase_q)
        orp_pkg::PH_HDR2: begin
          if (hdr1_q == orp_pkg::HDR_CODE_1 && b == orp_pkg::HDR_CODE_2) begin
            kind_d = orp_pkg::REC_CODE;
          end else if (hdr1_q == orp_pkg::HDR_DATA_1 && b == orp_pkg::HDR_DATA_2) begin
            kind_d = orp_pkg::REC_DATA;
          end else if (hdr1_q == orp_pkg::HDR_LABEL_1 && b == orp_pkg::HDR_LABEL_2) begin
            kind_d = orp_pkg::REC_LABEL;
          end else begin
            kind_d = orp_pkg::REC_UNKNOWN;
          end
          phase_d = orp_pkg::PH_ADDR_H;
        end
        orp_pkg::PH_ADDR_H: begin
          addr_d  = {b, 8'h00};
          phase_d = orp_pkg::PH_ADDR_L;
        end
        orp_pkg::PH_ADDR_L: begin
          addr_d  = {addr_q[15:8], b};
          phase_d = orp_pkg::PH_CNT_H;
        end
        orp_pkg::PH_CNT_H: begin
          count_d = {b, 8'h00};
          phase_d = orp_pkg::PH_CNT_L;
        end
        orp_pkg::PH_CNT_L: begin
          count_d = count_full;
          if (kind_q == orp_pkg::REC_UNKNOWN) begin
            phase_d = orp_pkg::PH_HDR1;
          end else if (count_full == 16'd0) begin
            phase_d = orp_pkg::PH_HDR1;
            if (kind_q == orp_pkg::REC_LABEL) begin
              res_valid_o               = 1'b1;
              res_data_o.item_kind      = orp_pkg::ITEM_LABEL_EMPTY;
              res_data_o.target_address = addr_q;
              res_data_o.label_last     = 1'b1;
            end
          end else if (kind_q == orp_pkg::REC_LABEL) begin
            phase_d = orp_pkg::PH_LABEL;
          end else begin
            phase_d = orp_pkg::PH_WORD_H;
          end
        end
        orp_pkg::PH_WORD_H: begin
          hi_d    = b;
          phase_d = orp_pkg::PH_WORD_L;
        end
        orp_pkg::PH_WORD_L: begin
          res_valid_o               = 1'b1;
          res_data_o.item_kind      = orp_pkg::ITEM_WORD;
          res_data_o.target_address = addr_q;
          res_data_o.item_value     = {hi_q, b};
          addr_d  = addr_q + 16'd1;
          count_d = count_q - 16'd1;
          phase_d = (count_q == 16'd1) ? orp_pkg::PH_HDR1 : orp_pkg::PH_WORD_H;
        end
        orp_pkg::PH_LABEL: begin
          res_valid_o               = 1'b1;
          res_data_o.item_kind      = orp_pkg::ITEM_LABEL_CHAR;
          res_data_o.target_address = addr_q;
          res_data_o.item_value     = {8'h00, b};
          res_data_o.label_last     = (count_q == 16'd1);
          count_d = count_q - 16'd1;
          if (count_q == 16'd1) begin
            phase_d = orp_pkg::PH_HDR1;
          end
        end
        default: begin
          // header first byte, and any unused phase code
          hdr1_d  = b;
          phase_d = orp_pkg::PH_HDR2;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= orp_pkg::PH_HDR1;
      hdr1_q  <= '0;
      kind_q  <= orp_pkg::REC_UNKNOWN;
      addr_q  <= '0;
      count_q <= '0;
      hi_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hdr1_q  <= hdr1_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      count_q <= count_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// File: hw/rtl/orp_out_reg.sv
// ----------------------------------------------------------------------------
// orp_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module orp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  orp_pkg::orp_out_t res_data_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output orp_pkg::orp_out_t out_data_o
);

  logic              valid_q, valid_d;
  orp_pkg::orp_out_t data_q;

  // Full and not draining this cycle.
  assign busy_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hw/rtl/object_record_parser.sv
// ----------------------------------------------------------------------------
// object_record_parser
// Parses an object-file byte stream into word writes and label items.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | orp_in_t  (data_byte, file_end)
//  out     | output    | out_valid_o/out_stall_i | orp_out_t (kind, addr, value, last)
//
//  One byte is taken per cycle; its result, if any, appears in the result
//  register on the next cycle. The only limit is that single result register.
//  Reset returns the parser to waiting for a header's first byte and empties
//  the result register. Input is stalled only while a result is held and the
//  receiver is stalling; a byte can be taken in the same cycle a result leaves.
//
module object_record_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  orp_pkg::orp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output orp_pkg::orp_out_t out_data_o
);

  logic              accept;
  logic              busy;
  logic              res_valid;
  orp_pkg::orp_out_t res_data;

  // Hold the input side whenever the result register cannot take a new value.
  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  // Advance the record state machine on every transfer.
  orp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  // Load the result register on each transfer; drop its value once taken.
  orp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_data_i  (res_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the object-file record parser. A queue of stream
// bytes (directed records first, then random records, broken records, noise
// and end-of-file marks) feeds a clocked driver. A clocked monitor checks
// every result transfer against items predicted by a parser model that runs
// on each accepted byte. Both channels idle at random, and the receiver
// holds off once for a long stretch so that the parser backs up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_COUNT     = 1800;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned MAX_IDLE       = 11;
  localparam int unsigned HOLD_AFTER     = 150;   // results taken before the long hold
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  orp_pkg::orp_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  orp_pkg::orp_out_t out_data_o;

  object_record_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Byte stream waiting to be sent, with the idle cycles that follow each byte
  // --------------------------------------------------------------------------
  orp_pkg::orp_in_t  byte_feed[$];
  int unsigned       byte_gaps[$];
  bit                tx_busy = 1'b1;

  // Items the parser still owes us, oldest first
  orp_pkg::orp_out_t awaited_items[$];

  int unsigned mismatch_cnt  = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles  = 0;
  bit          timed_out     = 1'b0;

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [3:0]  ph        = orp_pkg::PH_HDR1;
  logic [7:0]  hdr_first = '0;
  logic [1:0]  rec       = orp_pkg::REC_UNKNOWN;
  logic [15:0] cur_addr  = '0;
  logic [15:0] left      = '0;
  logic [7:0]  word_hi   = '0;

  task automatic await_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [15:0] val, input logic last);
    orp_pkg::orp_out_t r;
    r.item_kind      = kind;
    r.target_address = addr;
    r.item_value     = val;
    r.label_last     = last;
    awaited_items.push_back(r);
  endtask

  // Advance the model by one accepted byte and queue any item it yields.
  task automatic track_record_byte(input orp_pkg::orp_in_t t);
    logic [7:0] b;
    b = t.data_byte;
    if (t.file_end) begin
      // Drop any partial record and fall back to the reset state
      ph        = orp_pkg::PH_HDR1;
      hdr_first = '0;
      rec       = orp_pkg::REC_UNKNOWN;
      cur_addr  = '0;
      left      = '0;
      word_hi   = '0;
    end else begin
      case (ph)
        orp_pkg::PH_HDR2: begin
          if (hdr_first == orp_pkg::HDR_CODE_1 && b == orp_pkg::HDR_CODE_2) begin
            rec = orp_pkg::REC_CODE;
          end else if (hdr_first == orp_pkg::HDR_DATA_1 && b == orp_pkg::HDR_DATA_2) begin
            rec = orp_pkg::REC_DATA;
          end else if (hdr_first == orp_pkg::HDR_LABEL_1 &&
                       b == orp_pkg::HDR_LABEL_2) begin
            rec = orp_pkg::REC_LABEL;
          end else begin
            rec = orp_pkg::REC_UNKNOWN;
          end
          ph = orp_pkg::PH_ADDR_H;
        end
        orp_pkg::PH_ADDR_H: begin
          cur_addr = {b, 8'h00};
          ph       = orp_pkg::PH_ADDR_L;
        end
        orp_pkg::PH_ADDR_L: begin
          cur_addr[7:0] = b;
          ph            = orp_pkg::PH_CNT_H;
        end
        orp_pkg::PH_CNT_H: begin
          left = {b, 8'h00};
          ph   = orp_pkg::PH_CNT_L;
        end
        orp_pkg::PH_CNT_L: begin
          left[7:0] = b;
          if (rec == orp_pkg::REC_UNKNOWN) begin
            // Unknown header: only its six bytes are consumed
            ph = orp_pkg::PH_HDR1;
          end else if (left == 16'd0) begin
            ph = orp_pkg::PH_HDR1;
            if (rec == orp_pkg::REC_LABEL) begin
              await_item(orp_pkg::ITEM_LABEL_EMPTY, cur_addr, 16'h0000, 1'b1);
            end
          end else begin
            ph = (rec == orp_pkg::REC_LABEL) ? orp_pkg::PH_LABEL : orp_pkg::PH_WORD_H;
          end
        end
        orp_pkg::PH_WORD_H: begin
          word_hi = b;
          ph      = orp_pkg::PH_WORD_L;
        end
        orp_pkg::PH_WORD_L: begin
          await_item(orp_pkg::ITEM_WORD, cur_addr, {word_hi, b}, 1'b0);
          cur_addr = cur_addr + 16'd1;   // wraps at 16 bits
          left     = left - 16'd1;
          ph       = (left == 16'd0) ? orp_pkg::PH_HDR1 : orp_pkg::PH_WORD_H;
        end
        orp_pkg::PH_LABEL: begin
          await_item(orp_pkg::ITEM_LABEL_CHAR, cur_addr, {8'h00, b}, left == 16'd1);
          left = left - 16'd1;
          if (left == 16'd0) ph = orp_pkg::PH_HDR1;
        end
        default: begin
          // Header first byte; unused phase codes land here too
          hdr_first = b;
          ph        = orp_pkg::PH_HDR2;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic eof);
    orp_pkg::orp_in_t t;
    t.data_byte = b;
    t.file_end  = eof;
    byte_feed.push_back(t);
    byte_gaps.push_back(tx_busy ? $urandom_range(0, MAX_IDLE) : 0);
  endtask

  // Header, address and count, then body_len random payload bytes
  task automatic put_record(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [15:0] addr, input logic [15:0] cnt,
                            input int unsigned body_len);
    put_byte(h1, 1'b0);
    put_byte(h2, 1'b0);
    put_byte(addr[15:8], 1'b0);
    put_byte(addr[7:0], 1'b0);
    put_byte(cnt[15:8], 1'b0);
    put_byte(cnt[7:0], 1'b0);
    repeat (body_len) put_byte(8'($urandom), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next byte once the slot is free and its gap has passed
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) track_record_byte(in_data_i);
      // Hold the payload while stalled; otherwise idle or advance
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (byte_feed.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= byte_feed.pop_front();
          gap_left   = byte_gaps.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and receiver: check each result transfer, then draw a stall
  // --------------------------------------------------------------------------
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          rx_busy   = 1'b1;

  task automatic check_item(input orp_pkg::orp_out_t act);
    orp_pkg::orp_out_t exp;
    if (awaited_items.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT)
        $display("unexpected result: kind %0d addr %h value %h last %0d",
                 act.item_kind, act.target_address, act.item_value, act.label_last);
    end else begin
      exp = awaited_items.pop_front();
      if (exp.item_kind !== act.item_kind || exp.target_address !== act.target_address ||
          exp.item_value !== act.item_value || exp.label_last !== act.label_last) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("result mismatch: expected kind %0d addr %h value %h last %0d, %s",
                   exp.item_kind, exp.target_address, exp.item_value, exp.label_last,
                   $sformatf("got kind %0d addr %h value %h last %0d", act.item_kind,
                             act.target_address, act.item_value, act.label_last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_item(out_data_o);
        results_taken++;
        // Switch between stretches of random stalls and none at all
        if ($urandom_range(0, 63) == 0) rx_busy = !rx_busy;
        rx_wait = rx_busy ? $urandom_range(0, MAX_IDLE) : 0;
      end
      // Hold off once for a long stretch so the parser fills and stalls its input
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait     = rx_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else if (quiet_cycles < WATCHDOG_LIMIT) quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build the stream, release reset, wait for the drain, report
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned body;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [7:0]  h1;
    logic [7:0]  h2;

    // Code record at the top of memory: two words, address wraps, extreme values
    put_record(orp_pkg::HDR_CODE_1, orp_pkg::HDR_CODE_2, 16'hFFFF, 16'd2, 0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    // Label record with no characters gives one empty-label item
    put_record(orp_pkg::HDR_LABEL_1, orp_pkg::HDR_LABEL_2, 16'h0000, 16'd0, 0);
    // Near-miss header CA D3 is unknown: consume six bytes, yield nothing
    put_record(orp_pkg::HDR_CODE_1, 8'hD3, 16'h8000, 16'hFFFF, 0);
    // End of file mid-header drops the partial record
    put_byte(orp_pkg::HDR_DATA_1, 1'b0);
    put_byte(orp_pkg::HDR_DATA_2, 1'b0);
    put_byte(8'h7F, 1'b1);

    while (byte_feed.size() < ITEM_COUNT) begin
      if ($urandom_range(0, 15) == 0) tx_busy = !tx_busy;
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 7) == 0) ? (16'hFFFC | 16'($urandom_range(0, 3)))
                                         : 16'($urandom);
      cnt  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 40))
                                         : 16'($urandom_range(0, 8));
      if (pick < 28) begin
        put_record(orp_pkg::HDR_CODE_1, orp_pkg::HDR_CODE_2, addr, cnt, 2 * cnt);
      end else if (pick < 54) begin
        put_record(orp_pkg::HDR_DATA_1, orp_pkg::HDR_DATA_2, addr, cnt, 2 * cnt);
      end else if (pick < 80) begin
        put_record(orp_pkg::HDR_LABEL_1, orp_pkg::HDR_LABEL_2, addr, cnt, cnt);
      end else if (pick < 88) begin
        // Unknown header with arbitrary bytes
        h1 = 8'($urandom);
        h2 = 8'($urandom);
        put_record(h1, h2, addr, 16'($urandom), 0);
      end else if (pick < 93) begin
        // Valid header with a large count, cut short by end of file
        case ($urandom_range(0, 2))
          0: begin
            h1 = orp_pkg::HDR_CODE_1;
            h2 = orp_pkg::HDR_CODE_2;
          end
          1: begin
            h1 = orp_pkg::HDR_DATA_1;
            h2 = orp_pkg::HDR_DATA_2;
          end
          default: begin
            h1 = orp_pkg::HDR_LABEL_1;
            h2 = orp_pkg::HDR_LABEL_2;
          end
        endcase
        body = $urandom_range(0, 10);
        put_record(h1, h2, addr, 16'($urandom), body);
        put_byte(8'($urandom), 1'b1);
      end else if (pick < 97) begin
        // Noise bytes, then resynchronise with an end of file
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom), 1'b0);
        put_byte(8'($urandom), 1'b1);
      end else begin
        put_byte(8'($urandom), 1'b1);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out &&
           !(byte_feed.size() == 0 && !in_valid_i && awaited_items.size() == 0))
      @(posedge clk_i);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!timed_out && mismatch_cnt == 0 && awaited_items.size() == 0) begin
      $display("object_record_parser verification clean");
    end else begin
      $display("object_record_parser verification failed");
    end
    $finish;
  end

endmodule
